@@ rtl/drs_pkg.sv @@
// Package for the depth reprojection splatter: payload structs, FSM states,
// fixed-point widths. No dependencies.
package drs_pkg;

	typedef struct packed {
		logic        req_type;
		logic [9:0]  col;
		logic [8:0]  row;
		logic [15:0] depth;
		logic        depth_valid;
	} in_item_t;

	typedef struct packed {
		logic [7:0] hue;
		logic       painted;
	} out_item_t;

	localparam int CFG_IDX_W = 3;
	localparam int NUM_CFG = 6;
	localparam logic REQ_SPLAT = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// projected coordinate width (Q.26, fits 60 bits; keep margin)
	localparam int P_W = 64;
	localparam int Q_W = 64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC0,
		ST_MAC1,
		ST_MAC2,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_WIN,
		ST_PAINT,
		ST_RD_WAIT,
		ST_OUT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

@@ rtl/drs_div.sv @@
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on drs_pkg.
module drs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  num,
	input  logic signed [63:0]  den,
	output logic signed [63:0]  quot,
	output drs_pkg::div_ctl_t   ctl
);
	import drs_pkg::*;

	logic [63:0] rem_q, quo_q, dvs_q;
	logic [6:0]  cnt_q;
	logic        neg_q, busy_q, done_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[63] ? 64'(-num) : num;
			dvs_q <= den[63] ? 64'(-den) : den;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? 64'(-quo_q) : quo_q;
	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
endmodule

@@ rtl/depth_reproject_splat.sv @@
// Top level of the depth reprojection splatter: sequencer, projection MAC,
// frame memory. Depends on drs_pkg and drs_div.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, in_data (in_item_t)   | input
//  out     | out_valid, out_ready, out_data(out_item_t)| output
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | input
//
// A read passes through accept, memory read, and clear and result register; its result
// is registered in the last step, which holds while an earlier result still waits at
// the output. A splat passes through projection, two runs of the serial divider, window
// setup and painting of up to 4*HALF_WINDOW^2 pixels, possibly none.
// A splat with p2 == 0 ends after the projection; one with missing depth after the accept.
// After reset a clearing pass writes IMG_WIDTH*IMG_HEIGHT entries, one per
// cycle, before any item is accepted. in_ready is low while an item is worked.
module depth_reproject_splat #(
	parameter int IMG_WIDTH = 640,
	parameter int IMG_HEIGHT = 480,
	parameter int HALF_WINDOW = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  drs_pkg::in_item_t      in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output drs_pkg::out_item_t     out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [drs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_data
);
	import drs_pkg::*;

	localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = $clog2(IMG_WIDTH + 1);
	localparam int YW = $clog2(IMG_HEIGHT + 1);

	logic [8:0] mem [DEPTH];
	logic [8:0] rd_data_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_en;
	logic [8:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	logic signed [31:0] coef_q [12];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 12; i++) coef_q[i] <= '0;
		end else if (cfg_valid && cfg_ready && 32'(cfg_index) < NUM_CFG) begin
			coef_q[2 * cfg_index] <= cfg_data[31:0];
			coef_q[2 * cfg_index + 1] <= cfg_data[63:32];
		end
	end
	assign cfg_ready = 1'b1;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [AW:0] clr_q;
	logic [1:0] k_q;
	logic signed [63:0] acc_q, mul_q;
	logic [2:0] ph_q;
	logic signed [63:0] p_q [3];
	logic signed [63:0] tx_q, ty_q;
	logic div_start, div_sel_q;
	logic signed [63:0] div_num, div_quot;
	div_ctl_t div_ctl;
	logic [XW-1:0] x0_q, x1_q, x_q;
	logic [YW-1:0] y0_q, y1_q, y_q;
	logic [7:0] hue_q;
	out_item_t out_q;
	logic out_free;

	// output register can take a new result this cycle
	assign out_free = !out_valid || out_ready;

	drs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(p_q[2]), .quot(div_quot), .ctl(div_ctl)
	);
	assign div_num = div_sel_q ? p_q[1] : p_q[0];

	function automatic logic signed [63:0] clampv(logic signed [63:0] v, int hi);
		if (v < 0) return 64'sd0;
		if (v > 64'(hi)) return 64'(hi);
		return v;
	endfunction

	// hue = sat(trunc(255*(d-512)/1024))
	logic signed [31:0] hue_raw;
	logic signed [31:0] hue_num;
	assign hue_num = 32'sd255 * (32'($signed({1'b0, item_q.depth})) - 32'sd512);
	assign hue_raw = hue_num < 0 ? -((-hue_num) >>> 10) : (hue_num >>> 10);

	logic in_frame;
	assign in_frame = 32'(item_q.col) < IMG_WIDTH && 32'(item_q.row) < IMG_HEIGHT;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		div_start = 1'b0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_addr = AW'(32'(item_q.row) * IMG_WIDTH + 32'(item_q.col));
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q[AW-1:0];
				if (32'(clr_q) == DEPTH - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_ready) begin
					if (in_data.req_type == REQ_READ) state_d = ST_RD_WAIT;
					else if (in_data.depth_valid) state_d = ST_MAC0;
				end
			end
			ST_RD_WAIT: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					if (in_frame) begin
						wr_en = 1'b1;
						wr_addr = rd_addr;
					end
					state_d = ST_IDLE;
				end
			end
			ST_MAC0: if (ph_q == 3'd5 && k_q == 2'd2) state_d = ST_DIV_START;
			ST_MAC1, ST_MAC2: state_d = ST_MAC0;
			ST_DIV_START: begin
				if (p_q[2] == 0) state_d = ST_IDLE;
				else begin
					div_start = 1'b1;
					state_d = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: if (div_ctl.done) state_d = div_sel_q ? ST_WIN : ST_DIV_START;
			ST_WIN: state_d = ST_PAINT;
			ST_PAINT: begin
				if (x0_q >= x1_q || y0_q >= y1_q) state_d = ST_IDLE;
				else begin
					wr_en = 1'b1;
					wr_addr = AW'(32'(y_q) * IMG_WIDTH + 32'(x_q));
					wr_data = {1'b1, hue_q};
					if (x_q + 1'b1 == x1_q && y_q + 1'b1 == y1_q) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			div_sel_q <= 1'b0;
			k_q <= '0;
			ph_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_OUT && out_free) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q == ST_IDLE) begin
				div_sel_q <= 1'b0;
				k_q <= '0;
				ph_q <= '0;
			end
			if (state_q == ST_MAC0) begin
				if (ph_q == 3'd5) begin
					ph_q <= '0;
					k_q <= k_q + 2'd1;
				end else ph_q <= ph_q + 3'd1;
			end
			if (state_q == ST_DIV_WAIT && div_ctl.done) div_sel_q <= 1'b1;
		end
	end

	// MAC sequence per row k: ph0 mul M0*col, ph1 acc, mul M1*row, ph2 acc+=,
	// ph3 acc+=M2, ph4 mul d*acc, ph5 p = mul + t*1024
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) item_q <= in_data;
		if (state_q == ST_MAC0) begin
			unique case (ph_q)
				3'd0: mul_q <= 64'(coef_q[4*k_q]) * 64'($signed({1'b0, item_q.col}));
				3'd1: begin
					acc_q <= mul_q;
					mul_q <= 64'(coef_q[4*k_q+1]) * 64'($signed({1'b0, item_q.row}));
				end
				3'd2: acc_q <= acc_q + mul_q;
				3'd3: acc_q <= acc_q + 64'(coef_q[4*k_q+2]);
				3'd4: mul_q <= acc_q * 64'($signed({1'b0, item_q.depth}));
				3'd5: p_q[k_q] <= mul_q + (64'(coef_q[4*k_q+3]) <<< 10);
				default: ;
			endcase
		end
		if (state_q == ST_DIV_WAIT && div_ctl.done) begin
			if (div_sel_q) ty_q <= div_quot;
			else tx_q <= div_quot;
		end
		if (state_q == ST_WIN) begin
			x0_q <= XW'(clampv(tx_q - HALF_WINDOW, IMG_WIDTH));
			x1_q <= XW'(clampv(tx_q + HALF_WINDOW, IMG_WIDTH));
			y0_q <= YW'(clampv(ty_q - HALF_WINDOW, IMG_HEIGHT));
			y1_q <= YW'(clampv(ty_q + HALF_WINDOW, IMG_HEIGHT));
			x_q <= XW'(clampv(tx_q - HALF_WINDOW, IMG_WIDTH));
			y_q <= YW'(clampv(ty_q - HALF_WINDOW, IMG_HEIGHT));
			hue_q <= hue_raw < 0 ? 8'd0 : (hue_raw > 255 ? 8'd255 : hue_raw[7:0]);
		end
		if (state_q == ST_PAINT) begin
			if (x_q + 1'b1 == x1_q) begin
				x_q <= x0_q;
				y_q <= y_q + 1'b1;
			end else x_q <= x_q + 1'b1;
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.hue <= in_frame ? rd_data_q[7:0] : 8'd0;
			out_q.painted <= in_frame ? rd_data_q[8] : 1'b0;
		end
	end
	assign out_data = out_q;
endmodule

@@ tb/sv/tb_depth_reproject_splat.sv @@
// Self-checking testbench for depth_reproject_splat: splat and read-back traffic
// checked against an in-bench projection and frame-store model. Depends on drs_pkg.
module tb_depth_reproject_splat;
	import drs_pkg::*;

	localparam int W = 640;
	localparam int H = 480;
	localparam int HW = 5;
	localparam int SETTLE = 400;

	typedef struct {
		in_item_t  it;
		bit        fixed;
		out_item_t res;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_item_t          out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]        cfg_data;

	bit [8:0]   pix_store [0:W*H-1];
	longint     coef [0:11];
	out_item_t  pending_pixels [$];
	int         recent_x [$];
	int         recent_y [$];
	int         fails = 0;
	int         tx_idle = 0;
	int         rx_idle = 0;
	bit         rx_hold = 0;

	depth_reproject_splat u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		fails++;
	endtask

	function automatic longint sx32(input logic [31:0] w);
		return longint'(signed'(w));
	endfunction

	function automatic longint clampl(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Applies one transaction to the frame model; returns 1 when a pixel comes back.
	function automatic bit warp_predict(input in_item_t it, output out_item_t res);
		longint c, r, d, p0, p1, p2, tx, ty, hv, x0, x1, y0, y1;
		int idx;
		c = it.col;
		r = it.row;
		d = it.depth;
		res = '0;
		if (it.req_type == REQ_READ) begin
			if (c < W && r < H) begin
				idx = int'(r) * W + int'(c);
				res.hue = pix_store[idx][7:0];
				res.painted = pix_store[idx][8];
				pix_store[idx] = '0;
			end
			return 1;
		end
		if (!it.depth_valid) return 0;
		p0 = d * (coef[0] * c + coef[1] * r + coef[2]) + coef[3] * 1024;
		p1 = d * (coef[4] * c + coef[5] * r + coef[6]) + coef[7] * 1024;
		p2 = d * (coef[8] * c + coef[9] * r + coef[10]) + coef[11] * 1024;
		if (p2 == 0) return 0;
		tx = p0 / p2;
		ty = p1 / p2;
		hv = clampl((255 * (d - 512)) / 1024, 0, 255);
		x0 = clampl(tx - HW, 0, W);
		x1 = clampl(tx + HW, 0, W);
		y0 = clampl(ty - HW, 0, H);
		y1 = clampl(ty + HW, 0, H);
		for (longint y = y0; y < y1; y++)
			for (longint x = x0; x < x1; x++)
				pix_store[int'(y) * W + int'(x)] = {1'b1, hv[7:0]};
		if (tx > -64 && tx < 1100 && ty > -64 && ty < 600) begin
			recent_x = {recent_x, int'(tx)};
			recent_y = {recent_y, int'(ty)};
			if (recent_x.size() > 8) begin
				void'(recent_x.pop_front());
				void'(recent_y.pop_front());
			end
		end
		return 0;
	endfunction

	// Called at a falling edge; returns at a falling edge.
	task automatic send(input in_item_t it, input bit fixed, input out_item_t fx);
		out_item_t pr;
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (warp_predict(it, pr))
			pending_pixels = {pending_pixels, (fixed ? fx : pr)};
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input int idx, input logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx[CFG_IDX_W-1:0];
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_CFG) begin
			coef[2 * idx] = sx32(v[31:0]);
			coef[2 * idx + 1] = sx32(v[63:32]);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic cfg_all(input logic [63:0] v);
		for (int i = 0; i < NUM_CFG; i++) cfg_write(i, v);
	endtask

	task automatic cfg_identity();
		cfg_write(0, {32'h0, 32'h0001_0000});
		cfg_write(1, 64'h0);
		cfg_write(2, {32'h0001_0000, 32'h0});
		cfg_write(3, 64'h0);
		cfg_write(4, 64'h0);
		cfg_write(5, {32'h0, 32'h0001_0000});
	endtask

	// Mild scale, shift and perspective, so targets mostly stay in frame.
	task automatic cfg_random();
		logic [31:0] a, b, ox, oy, px, py, t2;
		a = $urandom_range(32'h1_8000, 32'h0_8000);
		b = $urandom_range(32'h1_8000, 32'h0_8000);
		ox = 32'($signed($urandom_range(400)) - 200) <<< 16;
		oy = 32'($signed($urandom_range(300)) - 150) <<< 16;
		px = 32'($signed($urandom_range(40)) - 20);
		py = 32'($signed($urandom_range(40)) - 20);
		t2 = 32'($signed($urandom_range(2000)) - 1000);
		cfg_write(0, {32'($signed($urandom_range(2000)) - 1000), a});
		cfg_write(1, {32'($signed($urandom_range(20000)) - 10000), ox});
		cfg_write(2, {b, 32'($signed($urandom_range(2000)) - 1000)});
		cfg_write(3, {32'($signed($urandom_range(20000)) - 10000), oy});
		cfg_write(4, {py, px});
		cfg_write(5, {t2, 32'h0001_0000});
	endtask

	function automatic in_item_t rand_item();
		in_item_t it;
		logic [63:0] rnd;
		int k, x, y;
		rnd = {$urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		if ($urandom_range(99) < 20) return it;
		it.depth_valid = 1'b1;
		if ($urandom_range(99) < 55) begin
			it.req_type = REQ_SPLAT;
			it.col = 10'($urandom_range(W - 1));
			it.row = 9'($urandom_range(H - 1));
			it.depth = 16'($urandom_range(8192, 300));
		end else begin
			it.req_type = REQ_READ;
			if (recent_x.size() != 0) begin
				k = $urandom_range(recent_x.size() - 1);
				x = recent_x[k] + $signed($urandom_range(11)) - 6;
				y = recent_y[k] + $signed($urandom_range(11)) - 6;
				if (x >= 0 && x < 1024) it.col = 10'(x);
				if (y >= 0 && y < 512) it.row = 9'(y);
			end
		end
		return it;
	endfunction

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++) send(rand_item(), 1'b0, '0);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (3000) @(negedge clk);
				rx_hold = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report("result with nothing expected");
			end else begin
				out_item_t e;
				e = pending_pixels.pop_front();
				if (out_data.hue !== e.hue)
					report($sformatf("hue got %0d want %0d", out_data.hue, e.hue));
				if (out_data.painted !== e.painted)
					report($sformatf("painted got %0b want %0b", out_data.painted, e.painted));
			end
		end
	end

	initial begin
		row_t dir [$];
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < 12; i++) coef[i] = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cfg_identity();
		cfg_write(6, 64'hDEAD_BEEF_0123_4567);
		cfg_write(7, 64'hFFFF_FFFF_FFFF_FFFF);

		//              req        col   row  depth   valid  fixed  hue  painted
		dir = '{
			'{'{REQ_READ,  10'd0,   9'd0,   16'd0,     1'b1}, 1, '{8'd0,   1'b0}},
			'{'{REQ_SPLAT, 10'd100, 9'd100, 16'd1024,  1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd100, 9'd100, 16'd0,     1'b0}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd100, 9'd100, 16'd0,     1'b0}, 1, '{8'd0,   1'b0}},
			'{'{REQ_SPLAT, 10'd200, 9'd50,  16'd1024,  1'b0}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd200, 9'd50,  16'd0,     1'b1}, 1, '{8'd0,   1'b0}},
			'{'{REQ_SPLAT, 10'd300, 9'd300, 16'd0,     1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd300, 9'd300, 16'd0,     1'b1}, 1, '{8'd0,   1'b0}},
			'{'{REQ_SPLAT, 10'd0,   9'd0,   16'hFFFF,  1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd0,   9'd0,   16'd0,     1'b1}, 1, '{8'd255, 1'b1}},
			'{'{REQ_READ,  10'd4,   9'd4,   16'd0,     1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_SPLAT, 10'd639, 9'd479, 16'd512,   1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd639, 9'd479, 16'd0,     1'b1}, 1, '{8'd0,   1'b1}},
			'{'{REQ_READ,  10'd634, 9'd474, 16'd0,     1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_SPLAT, 10'd1023,9'd511, 16'd600,   1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd639, 9'd479, 16'd0,     1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd1023,9'd511, 16'hFFFF,  1'b1}, 1, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd640, 9'd0,   16'd0,     1'b1}, 1, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd0,   9'd480, 16'd0,     1'b1}, 1, '{8'd0,   1'b0}},
			'{'{REQ_SPLAT, 10'd10,  9'd10,  16'd2000,  1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_SPLAT, 10'd12,  9'd12,  16'd800,   1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd10,  9'd10,  16'd0,     1'b1}, 0, '{8'd0,   1'b0}},
			'{'{REQ_READ,  10'd7,   9'd7,   16'd0,     1'b1}, 0, '{8'd0,   1'b0}}
		};
		foreach (dir[i]) send(dir[i].it, dir[i].fixed, dir[i].res);
		wait_idle();

		// extreme coefficient words
		cfg_all(64'hFFFF_FFFF_FFFF_FFFF);
		run_random(25);
		wait_idle();
		cfg_all(64'h7FFF_FFFF_7FFF_FFFF);
		run_random(25);
		wait_idle();
		cfg_all(64'h8000_0000_8000_0000);
		run_random(25);
		wait_idle();

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 18 : (ph == 1) ? 68 : 0;
			rx_idle = (ph == 0) ? 68 : (ph == 1) ? 18 : 0;
			for (int k = 0; k < 4; k++) begin
				if (k == 0) cfg_identity();
				else cfg_random();
				if (ph == 0 && k == 1) begin
					run_random(20);
					rx_hold = 1;
				end
				run_random(100);
				wait_idle();
			end
		end

		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
